// ----- rtl/imuq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuq_pkg
// Shared widths, codes and item types for the inertial sample qualifier
// and pair accumulator.
// ----------------------------------------------------------------------------
package imuq_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int TIME_W    = 48;
	localparam int STEP_W    = 20;
	localparam int SUMSTEP_W = STEP_W + 1;
	localparam int COUNT_W   = 8;
	localparam int GAP_W     = 4;
	localparam int ALLOW_W   = STEP_W + GAP_W;
	localparam int NUM_AXES  = 3;
	localparam int OUTCOME_W = 3;

	localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(3);

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic REG_GAP_MULT = 1'b0;

	localparam logic [OUTCOME_W-1:0] OUT_READ_FAIL = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_INVALID   = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_DUPLICATE = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_HELD      = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_PAIR      = 3'd4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic               read_ok;
		logic               sensor_valid;
		logic [TIME_W-1:0]  stamp_us;
		logic [STEP_W-1:0]  step_us;
		logic [COUNT_W-1:0] sample_count;
		sample_t            angle_x;
		sample_t            angle_y;
		sample_t            angle_z;
		sample_t            vel_x;
		sample_t            vel_y;
		sample_t            vel_z;
	} imuq_item_t;

	typedef struct packed {
		logic [OUTCOME_W-1:0] outcome;
		logic                 time_error;
		logic [TIME_W-1:0]    out_stamp_us;
		logic [SUMSTEP_W-1:0] out_step_us;
		sample_t              sum_angle_x;
		sample_t              sum_angle_y;
		sample_t              sum_angle_z;
		sample_t              sum_vel_x;
		sample_t              sum_vel_y;
		sample_t              sum_vel_z;
	} imuq_result_t;

	typedef struct packed {
		logic                             held_valid;
		logic [NUM_AXES-1:0][SAMPLE_W-1:0] held_angle;
		logic [NUM_AXES-1:0][SAMPLE_W-1:0] held_vel;
		logic [STEP_W-1:0]                held_step;
		logic                             prior_seen;
		logic [TIME_W-1:0]                prior_ts;
	} imuq_state_t;

endpackage

// ----- rtl/imuq_item_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuq_item_if
// Valid/ready channel carrying one sensor sample item.
// ----------------------------------------------------------------------------
interface imuq_item_if import imuq_pkg::*; ();
	logic       valid;
	logic       ready;
	imuq_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/imuq_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuq_result_if
// Valid/ready channel carrying one qualifier result item.
// ----------------------------------------------------------------------------
interface imuq_result_if import imuq_pkg::*; ();
	logic         valid;
	logic         ready;
	imuq_result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/imuq_apb_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuq_apb_regs
// APB register file holding the gap multiplier.
// ----------------------------------------------------------------------------
module imuq_apb_regs import imuq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [GAP_W-1:0]      gap_mult
);

	logic [GAP_W-1:0] gap_mult_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_mult_q <= GAP_RESET;
		end else if (wr_en && paddr[2] == REG_GAP_MULT) begin
			gap_mult_q <= pwdata[GAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_GAP_MULT: prdata = {{(APB_DATA_W-GAP_W){1'b0}}, gap_mult_q};
			default:      prdata = '0;
		endcase
	end

	assign gap_mult = gap_mult_q;

endmodule

// ----- rtl/imuq_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuq_eval
// Qualifies one registered sample against the held state and forms the
// result item and the next state.
// ----------------------------------------------------------------------------
module imuq_eval import imuq_pkg::*; (
	input  imuq_item_t       item,
	input  imuq_state_t      st,
	input  logic [GAP_W-1:0] gap_mult,
	output imuq_result_t     res,
	output imuq_state_t      st_nxt
);

	function automatic logic [SAMPLE_W-1:0] sat_add(
		input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b
	);
		logic [SAMPLE_W:0] s;
		s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
		if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
			sat_add = s[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
			                      : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			sat_add = s[SAMPLE_W-1:0];
		end
	endfunction

	logic [NUM_AXES-1:0][SAMPLE_W-1:0] in_angle;
	logic [NUM_AXES-1:0][SAMPLE_W-1:0] in_vel;
	logic [NUM_AXES-1:0][SAMPLE_W-1:0] sum_angle;
	logic [NUM_AXES-1:0][SAMPLE_W-1:0] sum_vel;
	logic [TIME_W-1:0]                 ts_diff;
	logic [ALLOW_W-1:0]                allowed;
	logic                              bad_sample;
	logic                              dup;
	logic                              backward;
	logic                              too_far;
	logic                              terr;

	assign in_angle = {item.angle_z, item.angle_y, item.angle_x};
	assign in_vel   = {item.vel_z, item.vel_y, item.vel_x};

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			sum_angle[i] = sat_add(st.held_angle[i], in_angle[i]);
			sum_vel[i]   = sat_add(st.held_vel[i], in_vel[i]);
		end
	end

	assign bad_sample = !item.sensor_valid || item.step_us == '0 || item.sample_count == '0;
	assign dup        = st.prior_seen && item.stamp_us == st.prior_ts;
	assign backward   = item.stamp_us < st.prior_ts;
	assign ts_diff    = item.stamp_us - st.prior_ts;
	assign allowed    = ALLOW_W'(item.step_us) * ALLOW_W'(gap_mult);
	assign too_far    = ts_diff > TIME_W'(allowed);
	assign terr       = st.prior_seen && (backward || too_far);

	always_comb begin
		res    = '0;
		st_nxt = st;
		if (!item.read_ok) begin
			res.outcome       = OUT_READ_FAIL;
			st_nxt.held_valid = 1'b0;
		end else if (bad_sample) begin
			res.outcome       = OUT_INVALID;
			st_nxt.held_valid = 1'b0;
		end else if (dup) begin
			res.outcome = OUT_DUPLICATE;
		end else begin
			st_nxt.prior_seen = 1'b1;
			st_nxt.prior_ts   = item.stamp_us;
			res.time_error    = terr;
			if (!st.held_valid || terr) begin
				res.outcome       = OUT_HELD;
				st_nxt.held_valid = 1'b1;
				st_nxt.held_angle = in_angle;
				st_nxt.held_vel   = in_vel;
				st_nxt.held_step  = item.step_us;
			end else begin
				res.outcome          = OUT_PAIR;
				res.out_stamp_us     = item.stamp_us;
				res.out_step_us      = SUMSTEP_W'(st.held_step) + SUMSTEP_W'(item.step_us);
				res.sum_angle_x      = sum_angle[0];
				res.sum_angle_y      = sum_angle[1];
				res.sum_angle_z      = sum_angle[2];
				res.sum_vel_x        = sum_vel[0];
				res.sum_vel_y        = sum_vel[1];
				res.sum_vel_z        = sum_vel[2];
				st_nxt.held_valid    = 1'b0;
			end
		end
	end

endmodule

// ----- rtl/imu_sample_qualify_pair_accumulate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_sample_qualify_pair_accumulate
// Qualifies inertial sensor samples and sums good pairs into half-rate items.
//
// Usage:
//   sample carries one sensor reading per item, result returns exactly one
//   item per accepted sample (outcome code, time error flag and, for an
//   emitted pair, the saturated sums with the newer timestamp).
//   The gap multiplier sits at APB byte address 0; write it only while no
//   item is in flight.
//   An accepted item is registered in the input register, evaluated
//   combinationally against the held sample and registered again in the
//   result register, which holds it until the receiver takes it.
//   One item per cycle is sustained while the receiver does not stall; the
//   held-sample and prior-timestamp update is registered with each item.
//   When the receiver stalls, the result register holds its item and the
//   input register can still take one more item; sample.ready drops only
//   when both are full.
//   Reset clears the held sample, the prior timestamp and the valid flags of
//   both registers, and sets the gap multiplier to 3.
// ----------------------------------------------------------------------------
module imu_sample_qualify_pair_accumulate import imuq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	imuq_item_if.sink             sample,
	imuq_result_if.source         result
);

	logic [GAP_W-1:0] gap_mult;
	imuq_item_t       item_s1;
	logic             valid_s1;
	imuq_state_t      st_q;
	imuq_state_t      st_nxt;
	imuq_result_t     res_d;
	imuq_result_t     res_q;
	logic             res_valid_q;
	logic             out_free;
	logic             advance;
	logic             in_acc;

	imuq_apb_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.gap_mult (gap_mult)
	);

	imuq_eval u_eval (
		.item     (item_s1),
		.st       (st_q),
		.gap_mult (gap_mult),
		.res      (res_d),
		.st_nxt   (st_nxt)
	);

	assign out_free     = !res_valid_q || result.ready;
	assign advance      = valid_s1 && out_free;
	assign sample.ready = !valid_s1 || out_free;
	assign in_acc       = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= sample.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			st_q        <= st_nxt;
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	// only a held result can carry a time error
	a_terr_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.time_error |-> res_q.outcome == OUT_HELD)
		else $error("time error on a non-held result");

	// step and timestamp fields stay zero unless a pair is emitted
	a_zero_unused: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.outcome != OUT_PAIR |->
		res_q.out_step_us == '0 && res_q.out_stamp_us == '0)
		else $error("nonzero pair fields outside a pair");

	// emitting a pair consumes the held sample
	a_pair_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_d.outcome == OUT_PAIR |=> !st_q.held_valid)
		else $error("held sample kept after pair");

	// a held result always leaves a held sample and a prior timestamp
	a_held_sets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_d.outcome == OUT_HELD |=> st_q.held_valid && st_q.prior_seen)
		else $error("held state not set");

	// input stalls only when both registers are full and the output is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> valid_s1 && res_valid_q && !result.ready)
		else $error("input stalled without cause");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the inertial sample qualifier and pair accumulator.
// A queue-fed driver sends sensor samples with random gaps while the result
// side stalls at random. Every accepted sample runs through a local
// qualify-and-pair predictor, and each result item is compared field by field
// with the oldest prediction. A directed burst comes first: read failures,
// invalid samples, duplicates, backward and too-large timestamp gaps, and
// saturating sums. Random sample streams follow under several gap multiplier
// settings, written over APB between phases and read back.
// ----------------------------------------------------------------------------
module tb_top;
	import imuq_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam logic [APB_ADDR_W-1:0] GAP_MULT_ADDR = APB_ADDR_W'(4 * int'(REG_GAP_MULT));
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [STEP_W-1:0] STEP_MAX = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	imuq_item_if   sample_ch ();
	imuq_result_if result_ch ();

	imu_sample_qualify_pair_accumulate dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sample  (sample_ch),
		.result  (result_ch)
	);

	// predictor state
	logic              held_ok;
	sample_t           held_ang [NUM_AXES];
	sample_t           held_vel [NUM_AXES];
	logic [STEP_W-1:0] held_step_us;
	logic              prior_ok;
	logic [TIME_W-1:0] prior_stamp;
	logic [GAP_W-1:0]  gap_mult_model;

	imuq_item_t   pending_samples [$];
	imuq_result_t expected_results [$];
	imuq_result_t predicted;

	int unsigned queued_total;
	int unsigned taken_total;
	int unsigned error_count;
	int unsigned outcome_tally [5];
	int unsigned time_error_total;
	int unsigned settings_used;

	logic        sample_took;
	logic        idle_off;
	int unsigned src_gap_left;
	int unsigned src_calm;
	int unsigned stall_left;
	int unsigned sink_calm;

	logic [TIME_W-1:0] stream_ts;
	logic [STEP_W-1:0] stream_step;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic sample_t sat_sum(sample_t a, sample_t b);
		logic signed [SAMPLE_W:0] wide;
		wide = $signed({a[SAMPLE_W-1], a}) + $signed({b[SAMPLE_W-1], b});
		if (wide[SAMPLE_W] != wide[SAMPLE_W-1])
			return wide[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
		return wide[SAMPLE_W-1:0];
	endfunction

	function automatic imuq_result_t qualify_sample(imuq_item_t s);
		imuq_result_t       r;
		logic [ALLOW_W-1:0] allowed;
		logic               terr;
		r = '0;
		terr = 1'b0;
		if (!s.read_ok) begin
			held_ok = 1'b0;
			r.outcome = OUT_READ_FAIL;
			return r;
		end
		if (!s.sensor_valid || s.step_us == '0 || s.sample_count == '0) begin
			held_ok = 1'b0;
			r.outcome = OUT_INVALID;
			return r;
		end
		if (prior_ok && s.stamp_us == prior_stamp) begin
			r.outcome = OUT_DUPLICATE;
			return r;
		end
		if (prior_ok) begin
			allowed = ALLOW_W'(s.step_us) * ALLOW_W'(gap_mult_model);
			terr = (s.stamp_us < prior_stamp) ||
				((s.stamp_us - prior_stamp) > TIME_W'(allowed));
			if (terr)
				held_ok = 1'b0;
		end
		prior_ok = 1'b1;
		prior_stamp = s.stamp_us;
		r.time_error = terr;
		if (!held_ok) begin
			held_ok = 1'b1;
			held_ang = '{s.angle_x, s.angle_y, s.angle_z};
			held_vel = '{s.vel_x, s.vel_y, s.vel_z};
			held_step_us = s.step_us;
			r.outcome = OUT_HELD;
			return r;
		end
		r.outcome = OUT_PAIR;
		r.out_stamp_us = s.stamp_us;
		r.out_step_us = SUMSTEP_W'(held_step_us) + SUMSTEP_W'(s.step_us);
		r.sum_angle_x = sat_sum(held_ang[0], s.angle_x);
		r.sum_angle_y = sat_sum(held_ang[1], s.angle_y);
		r.sum_angle_z = sat_sum(held_ang[2], s.angle_z);
		r.sum_vel_x = sat_sum(held_vel[0], s.vel_x);
		r.sum_vel_y = sat_sum(held_vel[1], s.vel_y);
		r.sum_vel_z = sat_sum(held_vel[2], s.vel_z);
		held_ok = 1'b0;
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	task automatic check_result(imuq_result_t want, imuq_result_t got);
		check_field("outcome", 64'(want.outcome), 64'(got.outcome));
		check_field("time_error", 64'(want.time_error), 64'(got.time_error));
		check_field("out_stamp_us", 64'(want.out_stamp_us), 64'(got.out_stamp_us));
		check_field("out_step_us", 64'(want.out_step_us), 64'(got.out_step_us));
		check_field("sum_angle_x", 64'(want.sum_angle_x), 64'(got.sum_angle_x));
		check_field("sum_angle_y", 64'(want.sum_angle_y), 64'(got.sum_angle_y));
		check_field("sum_angle_z", 64'(want.sum_angle_z), 64'(got.sum_angle_z));
		check_field("sum_vel_x", 64'(want.sum_vel_x), 64'(got.sum_vel_x));
		check_field("sum_vel_y", 64'(want.sum_vel_y), 64'(got.sum_vel_y));
		check_field("sum_vel_z", 64'(want.sum_vel_z), 64'(got.sum_vel_z));
	endtask

	// mostly no gap, some short ones, a few long, and now and then a calm stretch
	function automatic int unsigned idle_length(inout int unsigned calm);
		int unsigned r;
		if (idle_off)
			return 0;
		if (calm != 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 999);
		if (r < 8) begin
			calm = $urandom_range(40, 160);
			return 0;
		end
		if (r < 600)
			return 0;
		if (r < 950)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		sample_took = arst_n && sample_ch.valid && sample_ch.ready;
		if (sample_took) begin
			predicted = qualify_sample(sample_ch.payload);
			outcome_tally[predicted.outcome]++;
			if (predicted.time_error)
				time_error_total++;
			expected_results.push_back(predicted);
			taken_total++;
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("result item with no sample waiting");
				error_count++;
			end else begin
				check_result(expected_results.pop_front(), result_ch.payload);
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (!sample_ch.valid || sample_took) begin
			if (src_gap_left != 0) begin
				sample_ch.valid <= 1'b0;
				src_gap_left--;
			end else if (pending_samples.size() != 0) begin
				sample_ch.payload <= pending_samples.pop_front();
				sample_ch.valid <= 1'b1;
				src_gap_left = idle_length(src_calm);
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			stall_left = idle_length(sink_calm);
			result_ch.ready <= (stall_left == 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("imu_sample_qualify_pair_accumulate: mismatch");
		$finish;
	end

	task automatic apb_access(logic wr, logic [APB_ADDR_W-1:0] addr,
		logic [APB_DATA_W-1:0] data, output logic [APB_DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (taken_total != queued_total || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_gap_multiplier(logic [GAP_W-1:0] value);
		logic [APB_DATA_W-1:0] wdata;
		logic [APB_DATA_W-1:0] rdata;
		wait_drained();
		wdata = $urandom;
		wdata[GAP_W-1:0] = value;
		apb_access(1'b1, GAP_MULT_ADDR, wdata, rdata);
		gap_mult_model = value;
		settings_used++;
		apb_access(1'b0, GAP_MULT_ADDR, '0, rdata);
		if (rdata[GAP_W-1:0] !== value) begin
			$error("gap_multiplier readback: expected %0h, got %0h", value, rdata[GAP_W-1:0]);
			error_count++;
		end
	endtask

	task automatic queue_sample(imuq_item_t s);
		pending_samples.push_back(s);
		queued_total++;
	endtask

	function automatic imuq_item_t sample_of(logic ok, logic dv, logic [TIME_W-1:0] ts,
		logic [STEP_W-1:0] step, logic [COUNT_W-1:0] cnt, sample_t ang, sample_t vel);
		imuq_item_t s;
		s.read_ok = ok;
		s.sensor_valid = dv;
		s.stamp_us = ts;
		s.step_us = step;
		s.sample_count = cnt;
		s.angle_x = ang;
		s.angle_y = ang;
		s.angle_z = ang;
		s.vel_x = vel;
		s.vel_y = vel;
		s.vel_z = vel;
		return s;
	endfunction

	task automatic queue_directed();
		// rejected samples must not set the prior timestamp
		queue_sample(sample_of(1'b0, 1'b1, TIME_MAX, STEP_MAX, '1, SAMPLE_MAX, SAMPLE_MIN));
		queue_sample(sample_of(1'b1, 1'b0, 48'd1000, 20'd1000, 8'd4, 32'sd5, 32'sd6));
		queue_sample(sample_of(1'b1, 1'b1, 48'd1000, '0, 8'd4, 32'sd5, 32'sd6));
		queue_sample(sample_of(1'b1, 1'b1, 48'd1000, 20'd1000, '0, 32'sd5, 32'sd6));
		// hold, duplicate keeps the hold, then a saturating pair
		queue_sample(sample_of(1'b1, 1'b1, 48'd1000, 20'd1000, 8'd1, SAMPLE_MAX, SAMPLE_MIN));
		queue_sample(sample_of(1'b1, 1'b1, 48'd1000, 20'd1000, 8'd1, 32'sd9, 32'sd9));
		queue_sample(sample_of(1'b1, 1'b1, 48'd2000, 20'd1000, 8'd255, SAMPLE_MAX, SAMPLE_MIN));
		queue_sample(sample_of(1'b1, 1'b1, 48'd3000, 20'd1000, 8'd2, SAMPLE_MIN, SAMPLE_MAX));
		queue_sample(sample_of(1'b1, 1'b1, 48'd4000, 20'd1000, 8'd2, SAMPLE_MIN, SAMPLE_MAX));
		// gap exactly at the limit, then one past it, then backward
		queue_sample(sample_of(1'b1, 1'b1, 48'd7000, 20'd1000, 8'd3, 32'sd100, -32'sd100));
		queue_sample(sample_of(1'b1, 1'b1, 48'd10001, 20'd1000, 8'd3, 32'sd7, -32'sd7));
		queue_sample(sample_of(1'b1, 1'b1, 48'd5000, STEP_MAX, 8'd3, 32'sd1, 32'sd2));
		queue_sample(sample_of(1'b1, 1'b1, 48'd6000, STEP_MAX, 8'd3, 32'sd3, 32'sd4));
		queue_sample(sample_of(1'b1, 1'b1, TIME_MAX, 20'd1000, 8'd255, -32'sd1, 32'sd5));
		queue_sample(sample_of(1'b0, 1'b0, 48'd0, '0, '0, '0, '0));
		queue_sample(sample_of(1'b1, 1'b1, 48'd0, 20'd1000, 8'd8, -32'sd1, 32'sd5));
		queue_sample(sample_of(1'b1, 1'b1, 48'd1, 20'd1000, 8'd8, 32'sd1, -32'sd7));
		// invalid sample drops the hold
		queue_sample(sample_of(1'b1, 1'b1, 48'd2, 20'd1000, 8'd8, 32'sd11, 32'sd12));
		queue_sample(sample_of(1'b1, 1'b0, 48'd3, 20'd1000, 8'd8, 32'sd11, 32'sd12));
		queue_sample(sample_of(1'b1, 1'b1, 48'd3, 20'd1000, 8'd8, 32'sd13, 32'sd14));
		queue_sample(sample_of(1'b1, 1'b1, 48'd4, 20'd1, 8'd128, 32'sh40000000, 32'sh3fffffff));
	endtask

	function automatic sample_t random_sample_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return SAMPLE_MAX - sample_t'($urandom_range(0, 3));
		if (r == 1)
			return SAMPLE_MIN + sample_t'($urandom_range(0, 3));
		if (r == 2)
			return sample_t'($signed($urandom_range(0, 2000)) - 1000);
		return sample_t'($urandom);
	endfunction

	function automatic logic [STEP_W-1:0] random_step();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return STEP_W'($urandom_range(1, 5000));
		if (r < 95)
			return STEP_W'($urandom_range(1, int'(STEP_MAX)));
		return STEP_MAX;
	endfunction

	function automatic logic [TIME_W-1:0] random_base();
		if ($urandom_range(0, 4) == 0)
			return TIME_MAX - TIME_W'($urandom_range(0, 100000));
		return TIME_W'({$urandom, $urandom});
	endfunction

	// mostly well-formed streams with random content, the rest broken samples
	task automatic queue_random(int unsigned count);
		imuq_item_t        s;
		int unsigned       pick;
		logic [TIME_W-1:0] span;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			s.read_ok = 1'b1;
			s.sensor_valid = 1'b1;
			s.step_us = stream_step;
			s.sample_count = COUNT_W'($urandom_range(1, 255));
			s.angle_x = random_sample_value();
			s.angle_y = random_sample_value();
			s.angle_z = random_sample_value();
			s.vel_x = random_sample_value();
			s.vel_y = random_sample_value();
			s.vel_z = random_sample_value();
			span = TIME_W'(stream_step) * TIME_W'(gap_mult_model);
			if (pick < 4) begin
				s.read_ok = 1'b0;
				s.sensor_valid = 1'($urandom_range(0, 1));
				s.stamp_us = random_base();
				s.step_us = STEP_W'($urandom);
				s.sample_count = COUNT_W'($urandom);
			end else if (pick < 8) begin
				s.sensor_valid = 1'b0;
				s.stamp_us = stream_ts + TIME_W'(stream_step);
			end else if (pick < 11) begin
				s.step_us = '0;
				s.stamp_us = stream_ts + TIME_W'(stream_step);
			end else if (pick < 14) begin
				s.sample_count = '0;
				s.stamp_us = stream_ts + TIME_W'(stream_step);
			end else if (pick < 19) begin
				s.stamp_us = stream_ts;
			end else if (pick < 24) begin
				stream_ts = stream_ts - TIME_W'($urandom_range(1, 5000));
				s.stamp_us = stream_ts;
			end else if (pick < 30) begin
				stream_ts = stream_ts + span + TIME_W'($urandom_range(0, 2));
				s.stamp_us = stream_ts;
			end else if (pick < 33) begin
				stream_step = random_step();
				stream_ts = random_base();
				s.step_us = stream_step;
				s.stamp_us = stream_ts;
			end else begin
				stream_ts = stream_ts + TIME_W'(stream_step)
					- TIME_W'($urandom_range(0, int'(stream_step) / 4));
				s.stamp_us = stream_ts;
			end
			queue_sample(s);
		end
	endtask

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.payload = '0;
		result_ch.ready = 1'b0;
		sample_took = 1'b0;
		idle_off = 1'b0;
		src_gap_left = 0;
		src_calm = 0;
		stall_left = 0;
		sink_calm = 0;
		held_ok = 1'b0;
		held_ang = '{default: '0};
		held_vel = '{default: '0};
		held_step_us = '0;
		prior_ok = 1'b0;
		prior_stamp = '0;
		gap_mult_model = GAP_RESET;
		queued_total = 0;
		taken_total = 0;
		error_count = 0;
		outcome_tally = '{default: 0};
		time_error_total = 0;
		settings_used = 1;
		stream_ts = 48'd100000;
		stream_step = 20'd1000;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_directed();
		set_gap_multiplier(4'd15);
		queue_random(400);
		set_gap_multiplier(4'd1);
		queue_random(350);
		// zero makes every forward gap an error
		set_gap_multiplier(4'd0);
		queue_random(150);
		repeat (3) begin
			set_gap_multiplier(GAP_W'($urandom_range(2, 14)));
			queue_random(200);
		end
		set_gap_multiplier(GAP_RESET);
		idle_off = 1'b1;
		queue_random(150);
		wait_drained();

		$display("%0d samples checked: %0d read fail, %0d invalid, %0d duplicate, %0d held, %0d pairs",
			taken_total, outcome_tally[OUT_READ_FAIL], outcome_tally[OUT_INVALID],
			outcome_tally[OUT_DUPLICATE], outcome_tally[OUT_HELD], outcome_tally[OUT_PAIR]);
		$display("%0d timestamp errors across %0d gap multiplier settings",
			time_error_total, settings_used);
		if (error_count == 0) begin
			$display("imu_sample_qualify_pair_accumulate: match");
		end else begin
			$display("imu_sample_qualify_pair_accumulate: mismatch");
		end
		$finish;
	end

endmodule
